// ===== hw/rtl/grid_cut_fill_volume_unit_defines.svh =====
// Assertion macros shared by the cut-and-fill volume RTL.
// No dependencies; the including file provides clock and reset.
`ifndef GRID_CUT_FILL_VOLUME_UNIT_DEFINES_SVH
`define GRID_CUT_FILL_VOLUME_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GCFV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcfv assertion failed");
`define GCFV_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcfv assertion failed");
`else
`define GCFV_ASSERT_IMP(label, ante, cons)
`define GCFV_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/gcfv_pkg.sv =====
// Types and constants of the cut-and-fill volume unit.
// No dependencies; used by the top level, queue, front, back and testbench.
package gcfv_pkg;
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int QUEUE_DEPTH = 2;
   localparam int ADDR_W      = 5;

   localparam logic [2:0] REG_GROUND_FROM_FIXED   = 3'd0;
   localparam logic [2:0] REG_GROUND_FIXED_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CEIL_FROM_FIXED     = 3'd2;
   localparam logic [2:0] REG_CEIL_FIXED_HEIGHT   = 3'd3;
   localparam logic [2:0] REG_GRID_WIDTH          = 3'd4;
   localparam logic [2:0] REG_GRID_HEIGHT         = 3'd5;
   localparam logic [2:0] REG_CELL_AREA           = 3'd6;

   localparam logic [62:0] LIM63 = {63{1'b1}};
   localparam logic [47:0] LIM48 = {48{1'b1}};

   typedef struct packed {
      logic               ground_from_fixed;
      logic signed [31:0] ground_fixed_height;
      logic               ceil_from_fixed;
      logic signed [31:0] ceil_fixed_height;
      logic [12:0]        grid_width;
      logic [12:0]        grid_height;
      logic [31:0]        cell_area;
   } cfg_type;

   typedef struct packed {
      logic signed [32:0] hc;
      logic               valid;
      logic               vg;
      logic               vc;
      logic [16:0]        ratio;
      logic               last;
      logic [3:0]         nb;
      logic               nb_en;
   } cell_type;
endpackage

// ===== hw/rtl/gcfv_if.sv =====
// Valid/ready channel interfaces for cells in and results out.
// No dependencies.
interface gcfv_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ground_height;
   logic               ground_valid;
   logic signed [31:0] ceil_height;
   logic               ceil_valid;
   logic [16:0]        area_ratio;
   modport source (output valid, ground_height, ground_valid, ceil_height, ceil_valid,
                   area_ratio, input ready);
   modport sink (input valid, ground_height, ground_valid, ceil_height, ceil_valid,
                 area_ratio, output ready);
endinterface

interface gcfv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [32:0] cell_height;
   logic               cell_valid;
   logic               report_ready;
   logic signed [63:0] net_volume;
   logic [62:0]        added_volume;
   logic [62:0]        removed_volume;
   logic [62:0]        surface_area;
   logic [24:0]        matching_cells;
   logic [24:0]        ground_only_cells;
   logic [24:0]        ceil_only_cells;
   logic [27:0]        neighbor_sum;
   logic [24:0]        interior_valid_cells;
   modport source (output valid, cell_height, cell_valid, report_ready, net_volume,
                   added_volume, removed_volume, surface_area, matching_cells,
                   ground_only_cells, ceil_only_cells, neighbor_sum,
                   interior_valid_cells, input ready);
   modport sink (input valid, cell_height, cell_valid, report_ready, net_volume,
                 added_volume, removed_volume, surface_area, matching_cells,
                 ground_only_cells, ceil_only_cells, neighbor_sum,
                 interior_valid_cells, output ready);
endinterface

// ===== hw/rtl/grid_cut_fill_volume_unit.sv =====
// Top level of the cut-and-fill volume unit: register file, front, queue, back.
// Depends on gcfv_pkg, gcfv_if, gcfv_front, gcfv_queue, gcfv_back and the defines.
//
//   channel  direction  handshake          carries
//   req      in         valid/ready        one grid cell, raster order
//   rsp      out        valid/ready        per-cell height, totals on last cell
//   csr      in         psel/penable APB   seven configuration registers
//
// The front ends each cell before taking the next: capture, line-store read and
// multiply, round and push, where a full queue holds it. The line store has one
// read and one write port; it is read on capture and written in the cycle after.
// The back drains an ordinary cell whenever the output register can load; for the
// last cell of a grid four totals pass in turn through one 32x32 multiplier (two
// partial products and a saturate each), then B_OUT loads the result.
// Reset is synchronous and clears all control and accumulator state; the line
// store is not cleared, its stale entries never reach a result.
// A stalled result holds in the output register while the queue absorbs up to
// two more cells.
`include "grid_cut_fill_volume_unit_defines.svh"
module grid_cut_fill_volume_unit (
   input  logic                         clock,
   input  logic                         reset,
   gcfv_req_if.sink                     req,
   gcfv_rsp_if.source                   rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gcfv_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import gcfv_pkg::*;

   cfg_type  cfg_ff;
   logic     wr;
   logic     q_push, q_full, q_pop, q_empty;
   cell_type q_in, q_out;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   // Register file: word-addressed, written in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_from_fixed   <= 1'b0;
         cfg_ff.ground_fixed_height <= '0;
         cfg_ff.ceil_from_fixed     <= 1'b0;
         cfg_ff.ceil_fixed_height   <= '0;
         cfg_ff.grid_width          <= 13'd1;
         cfg_ff.grid_height         <= 13'd1;
         cfg_ff.cell_area           <= 32'd65536;
      end else if (wr) begin
         unique case (paddr[ADDR_W-1:2])
            REG_GROUND_FROM_FIXED:   cfg_ff.ground_from_fixed   <= pwdata[0];
            REG_GROUND_FIXED_HEIGHT: cfg_ff.ground_fixed_height <= pwdata;
            REG_CEIL_FROM_FIXED:     cfg_ff.ceil_from_fixed     <= pwdata[0];
            REG_CEIL_FIXED_HEIGHT:   cfg_ff.ceil_fixed_height   <= pwdata;
            REG_GRID_WIDTH:          cfg_ff.grid_width          <= pwdata[12:0];
            REG_GRID_HEIGHT:         cfg_ff.grid_height         <= pwdata[12:0];
            REG_CELL_AREA:           cfg_ff.cell_area           <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1:2])
         REG_GROUND_FROM_FIXED:   prdata = {31'd0, cfg_ff.ground_from_fixed};
         REG_GROUND_FIXED_HEIGHT: prdata = cfg_ff.ground_fixed_height;
         REG_CEIL_FROM_FIXED:     prdata = {31'd0, cfg_ff.ceil_from_fixed};
         REG_CEIL_FIXED_HEIGHT:   prdata = cfg_ff.ceil_fixed_height;
         REG_GRID_WIDTH:          prdata = {19'd0, cfg_ff.grid_width};
         REG_GRID_HEIGHT:         prdata = {19'd0, cfg_ff.grid_height};
         REG_CELL_AREA:           prdata = cfg_ff.cell_area;
         default:                 prdata = '0;
      endcase
   end

   // Classify cells and track the raster position.
   gcfv_front u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req),
      .q_push(q_push),
      .q_data(q_in),
      .q_full(q_full)
   );

   // Decouple front from back so each can stall on its own.
   gcfv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_data (q_out)
   );

   // Accumulate, scale on the last cell, drive results.
   gcfv_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_empty(q_empty),
      .q_data (q_out),
      .q_pop  (q_pop),
      .rsp    (rsp)
   );

   `GCFV_ASSERT_IMP(a_no_push_when_full, q_full, !q_push)
   `GCFV_ASSERT_IMP(a_no_pop_when_empty, q_empty, !q_pop)
   `GCFV_ASSERT_IMP(a_totals_only_at_end, rsp.valid && !rsp.report_ready,
                    rsp.net_volume == '0 && rsp.matching_cells == '0)
   `GCFV_ASSERT_IMP(a_invalid_cell_zero, rsp.valid && !rsp.cell_valid, rsp.cell_height == '0)
endmodule

// ===== hw/rtl/gcfv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcfv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/gcfv_queue.sv =====
// Short register queue of classified cells between front and back.
// Depends on gcfv_pkg.
module gcfv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gcfv_pkg::cell_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output gcfv_pkg::cell_type pop_data
);
   import gcfv_pkg::*;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cell_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   assign full     = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/gcfv_front.sv =====
// Front end: accepts cells, classifies them, runs the 3x3 validity window.
// Depends on gcfv_pkg, gcfv_if and gcfv_ram.
module gcfv_front (
   input  logic               clock,
   input  logic               reset,
   input  gcfv_pkg::cfg_type  cfg,
   gcfv_req_if.sink           req,
   output logic               q_push,
   output gcfv_pkg::cell_type q_data,
   input  logic               q_full
);
   import gcfv_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [8:0]         win_ff, win_in;
   logic signed [31:0] gh_ff, ch_ff;
   logic               gv_ff, cv_ff;
   logic [16:0]        ratio_ff;
   logic signed [50:0] prod_ff, prod_in;
   cell_type           ent_ff, ent_in;

   logic               accept;
   logic [16:0]        ratio;
   logic signed [31:0] g, c;
   logic               vg, vc, valid;
   logic signed [32:0] diff;
   logic [1:0]         line_rd;
   logic [2:0]         colbits;
   logic [8:0]         win_new, win_nb;
   logic [13:0]        w_eff, h_eff;
   logic               last_col, last;
   logic signed [51:0] rounded;

   assign req.ready = state_ff == S_IDLE;
   assign accept    = req.valid && req.ready;

   // Line store entry: bit 0 is two rows up, bit 1 is one row up.
   gcfv_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_line (
      .clock  (clock),
      .wr_en  (state_ff == S_MUL),
      .wr_addr(col_ff),
      .wr_data({valid, line_rd[1]}),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(line_rd)
   );

   always_comb begin
      ratio   = (ratio_ff > 17'd65536) ? 17'd65536 : ratio_ff;
      g       = cfg.ground_from_fixed ? cfg.ground_fixed_height : gh_ff;
      c       = cfg.ceil_from_fixed ? cfg.ceil_fixed_height : ch_ff;
      vg      = cfg.ground_from_fixed || (gv_ff && ratio != '0);
      vc      = cfg.ceil_from_fixed || (cv_ff && ratio != '0);
      valid   = vg && vc;
      diff    = 33'(c) - 33'(g);
      prod_in = valid ? 51'(diff) * 51'($signed({1'b0, ratio})) : '0;
      colbits = {valid, line_rd[1], line_rd[0]};
      win_new = {colbits, win_ff[8:3]};
      win_nb  = win_new & 9'b111101111;
      w_eff   = (cfg.grid_width == '0) ? 14'd1 :
                ({1'b0, cfg.grid_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) :
                {1'b0, cfg.grid_width};
      h_eff   = (cfg.grid_height == '0) ? 14'd1 :
                ({1'b0, cfg.grid_height} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) :
                {1'b0, cfg.grid_height};
      last_col = 14'(col_ff) + 14'd1 >= w_eff;
      last     = last_col && (14'(row_ff) + 14'd1 >= h_eff);

      ent_in       = ent_ff;
      ent_in.valid = valid;
      ent_in.vg    = vg;
      ent_in.vc    = vc;
      ent_in.ratio = ratio;
      ent_in.last  = last;
      ent_in.nb    = 4'($countones(win_nb));
      ent_in.nb_en = row_ff >= ROW_W'(2) && col_ff >= COL_W'(2) && win_new[4];

      // Round half up: floor((p + 32768) / 65536).
      rounded   = 52'(prod_ff) + 52'sd32768;
      q_data    = ent_ff;
      q_data.hc = rounded[48:16];
      q_push    = state_ff == S_PUSH && !q_full;

      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      win_in   = win_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_PUSH;
            win_in   = win_new;
            if (last) begin
               row_in = '0;
               col_in = '0;
               win_in = '0;
            end else if (last_col) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         win_ff   <= win_in;
      end
      if (accept) begin
         gh_ff    <= req.ground_height;
         gv_ff    <= req.ground_valid;
         ch_ff    <= req.ceil_height;
         cv_ff    <= req.ceil_valid;
         ratio_ff <= req.area_ratio;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= prod_in;
         ent_ff  <= ent_in;
      end
   end
endmodule

// ===== hw/rtl/gcfv_back.sv =====
// Back end: accumulates totals, scales them by cell area, drives results.
// Depends on gcfv_pkg and gcfv_if.
module gcfv_back (
   input  logic               clock,
   input  logic               reset,
   input  gcfv_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  gcfv_pkg::cell_type q_data,
   output logic               q_pop,
   gcfv_rsp_if.source         rsp
);
   import gcfv_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_LO   = 3'd1;
   localparam logic [2:0] B_HI   = 3'd2;
   localparam logic [2:0] B_FIN  = 3'd3;
   localparam logic [2:0] B_OUT  = 3'd4;

   localparam logic [1:0] SEL_NET     = 2'd0;
   localparam logic [1:0] SEL_ADDED   = 2'd1;
   localparam logic [1:0] SEL_REMOVED = 2'd2;
   localparam logic [1:0] SEL_SURFACE = 2'd3;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         sel_ff;
   logic signed [63:0] vol_ff, vol_in;
   logic [62:0]        add_ff, add_in, rem_ff, rem_in;
   logic [47:0]        surf_ff, surf_in;
   logic [24:0]        match_ff, match_in, gonly_ff, gonly_in, conly_ff, conly_in;
   logic [27:0]        nb_ff, nb_in;
   logic [24:0]        inter_ff, inter_in;
   logic [63:0]        lo_ff, hi_ff;
   logic signed [63:0] net_res_ff;
   logic [62:0]        add_res_ff, rem_res_ff, surf_res_ff;
   logic signed [32:0] hold_hc_ff;
   logic               hold_valid_ff;

   logic               can_load;
   logic               neg;
   logic [63:0]        mag, lim, mul, q, qs;
   logic [31:0]        mul_op;
   logic signed [64:0] vsum;
   logic [63:0]        usum;
   logic [48:0]        ssum;
   logic [28:0]        nsum;

   assign can_load = !rsp.valid || rsp.ready;
   assign q_pop    = state_ff == B_IDLE && !q_empty && can_load;

   always_comb begin
      neg = vol_ff[63];
      case (sel_ff)
         SEL_NET:     mag = neg ? 64'(-vol_ff) : 64'(vol_ff);
         SEL_ADDED:   mag = {1'b0, add_ff};
         SEL_REMOVED: mag = {1'b0, rem_ff};
         default:     mag = {16'd0, surf_ff};
      endcase
      lim    = (sel_ff == SEL_NET && neg) ? 64'h8000_0000_0000_0000 : {1'b0, LIM63};
      mul_op = (state_ff == B_HI) ? mag[63:32] : mag[31:0];
      mul    = 64'(mul_op) * 64'(cfg.cell_area);
      q      = {hi_ff[47:0], 16'd0} + {16'd0, lo_ff[63:16]};
      qs     = (hi_ff >= 64'h0000_8000_0000_0000 || q > lim) ? lim : q;

      // Saturating accumulation of one popped cell.
      vol_in   = vol_ff;
      add_in   = add_ff;
      rem_in   = rem_ff;
      surf_in  = surf_ff;
      match_in = match_ff;
      gonly_in = gonly_ff;
      conly_in = conly_ff;
      nb_in    = nb_ff;
      inter_in = inter_ff;
      vsum = 65'(vol_ff) + 65'(q_data.hc);
      usum = 64'(add_ff) + 64'(q_data.hc[31:0]);
      ssum = 49'(surf_ff) + 49'(q_data.ratio);
      nsum = 29'(nb_ff) + 29'(q_data.nb);
      if (q_data.valid) begin
         if (vsum[64] != vsum[63]) begin
            vol_in = vsum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
         end else begin
            vol_in = vsum[63:0];
         end
         if (q_data.hc > 0) begin
            usum   = 64'(add_ff) + 64'(q_data.hc[31:0]);
            add_in = usum[63] ? LIM63 : usum[62:0];
         end else if (q_data.hc < 0) begin
            usum   = 64'(rem_ff) + 64'(33'(-q_data.hc));
            rem_in = usum[63] ? LIM63 : usum[62:0];
         end
         surf_in  = ssum[48] ? LIM48 : ssum[47:0];
         match_in = (&match_ff) ? match_ff : match_ff + 1'b1;
      end else if (q_data.vg) begin
         gonly_in = (&gonly_ff) ? gonly_ff : gonly_ff + 1'b1;
      end else if (q_data.vc) begin
         conly_in = (&conly_ff) ? conly_ff : conly_ff + 1'b1;
      end
      if (q_data.nb_en) begin
         nb_in    = nsum[28] ? {28{1'b1}} : nsum[27:0];
         inter_in = (&inter_ff) ? inter_ff : inter_ff + 1'b1;
      end

      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: state_in = (q_pop && q_data.last) ? B_LO : B_IDLE;
         B_LO:   state_in = B_HI;
         B_HI:   state_in = B_FIN;
         B_FIN:  state_in = (sel_ff == SEL_SURFACE) ? B_OUT : B_LO;
         B_OUT:  state_in = can_load ? B_IDLE : B_OUT;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         sel_ff    <= SEL_NET;
         rsp.valid <= 1'b0;
         vol_ff    <= '0;
         add_ff    <= '0;
         rem_ff    <= '0;
         surf_ff   <= '0;
         match_ff  <= '0;
         gonly_ff  <= '0;
         conly_ff  <= '0;
         nb_ff     <= '0;
         inter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            vol_ff   <= vol_in;
            add_ff   <= add_in;
            rem_ff   <= rem_in;
            surf_ff  <= surf_in;
            match_ff <= match_in;
            gonly_ff <= gonly_in;
            conly_ff <= conly_in;
            nb_ff    <= nb_in;
            inter_ff <= inter_in;
            sel_ff   <= SEL_NET;
         end
         if (state_ff == B_FIN) begin
            sel_ff <= sel_ff + 1'b1;
         end
         if (state_ff == B_OUT && can_load) begin
            vol_ff   <= '0;
            add_ff   <= '0;
            rem_ff   <= '0;
            surf_ff  <= '0;
            match_ff <= '0;
            gonly_ff <= '0;
            conly_ff <= '0;
            nb_ff    <= '0;
            inter_ff <= '0;
         end
         if ((q_pop && !q_data.last) || (state_ff == B_OUT && can_load)) begin
            rsp.valid <= 1'b1;
         end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
         end
      end

      if (state_ff == B_LO) begin
         lo_ff <= mul + 64'd32768;
      end
      if (state_ff == B_HI) begin
         hi_ff <= mul;
      end
      if (state_ff == B_FIN) begin
         case (sel_ff)
            SEL_NET:     net_res_ff  <= neg ? $signed(-qs) : $signed(qs);
            SEL_ADDED:   add_res_ff  <= qs[62:0];
            SEL_REMOVED: rem_res_ff  <= qs[62:0];
            default:     surf_res_ff <= qs[62:0];
         endcase
      end
      if (q_pop) begin
         hold_hc_ff    <= q_data.valid ? q_data.hc : '0;
         hold_valid_ff <= q_data.valid;
      end

      if (q_pop && !q_data.last) begin
         rsp.cell_height          <= q_data.valid ? q_data.hc : '0;
         rsp.cell_valid           <= q_data.valid;
         rsp.report_ready         <= 1'b0;
         rsp.net_volume           <= '0;
         rsp.added_volume         <= '0;
         rsp.removed_volume       <= '0;
         rsp.surface_area         <= '0;
         rsp.matching_cells       <= '0;
         rsp.ground_only_cells    <= '0;
         rsp.ceil_only_cells      <= '0;
         rsp.neighbor_sum         <= '0;
         rsp.interior_valid_cells <= '0;
      end else if (state_ff == B_OUT && can_load) begin
         rsp.cell_height          <= hold_hc_ff;
         rsp.cell_valid           <= hold_valid_ff;
         rsp.report_ready         <= 1'b1;
         rsp.net_volume           <= net_res_ff;
         rsp.added_volume         <= add_res_ff;
         rsp.removed_volume       <= rem_res_ff;
         rsp.surface_area         <= surf_res_ff;
         rsp.matching_cells       <= match_ff;
         rsp.ground_only_cells    <= gonly_ff;
         rsp.ceil_only_cells      <= conly_ff;
         rsp.neighbor_sum         <= nb_ff;
         rsp.interior_valid_cells <= inter_ff;
      end
   end
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the cut-and-fill volume unit: drives cells and register
// writes, predicts every result and compares it field by field.
// Depends on gcfv_pkg, the channel interfaces and grid_cut_fill_volume_unit.
module tb_top;
   import gcfv_pkg::*;

   // Clock, reset and the APB-style register port.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   gcfv_req_if req ();
   gcfv_rsp_if rsp ();

   logic              psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata, prdata;

   grid_cut_fill_volume_unit DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   typedef struct {
      logic signed [32:0] height;
      logic               valid;
      logic               last;
      logic signed [63:0] net;
      logic [62:0]        added;
      logic [62:0]        removed;
      logic [62:0]        surface;
      logic [24:0]        matching;
      logic [24:0]        ground_only;
      logic [24:0]        ceil_only;
      logic [27:0]        neighbours;
      logic [24:0]        interior;
   } cell_report_type;

   cell_report_type pending_reports[$];
   int           errors    = 0;
   int           cells_sent = 0;
   bit           calm      = 1'b0;   // no idling on either side once set
   int           quiet_cycles = 0;

   // Shadow of the register file and of the grid accumulators.
   cfg_type     shadow_cfg = '{ground_from_fixed: 1'b0, ground_fixed_height: '0,
                               ceil_from_fixed: 1'b0, ceil_fixed_height: '0,
                               grid_width: 13'd1, grid_height: 13'd1,
                               cell_area: 32'd65536};
   bit [11:0]   row_pos, col_pos;
   longint      net_sum;
   bit [63:0]   added_sum, removed_sum, surface_sum;
   bit [24:0]   match_n, ground_only_n, ceil_only_n, interior_n;
   bit [27:0]   neighbour_sum;
   bit          upper_row [MAX_WIDTH];
   bit          middle_row [MAX_WIDTH];
   bit [8:0]    window;

   function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, lim}) ? lim : s[63:0];
   endfunction

   // Rounded product with a Q16.16 area, clipped to lim.
   function automatic bit [63:0] scale_by_area(bit [63:0] m, bit [31:0] area, bit [63:0] lim);
      bit [127:0] q;
      q = ({64'd0, m} * {96'd0, area} + 128'd32768) >> 16;
      return (q > {64'd0, lim}) ? lim : q[63:0];
   endfunction

   function automatic cell_report_type predict_cell(logic signed [31:0] gh, logic gv,
                                                    logic signed [31:0] ch, logic cv,
                                                    logic [16:0] ratio_in);
      int unsigned       w, h;
      bit [16:0]         r;
      longint            g, c, p, hc;
      logic signed [64:0] s;
      bit                vg, vc, ok, last_col, last_cell;
      bit [28:0]         nb;
      cell_report_type   res;
      w = shadow_cfg.grid_width;
      h = shadow_cfg.grid_height;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      r = (ratio_in > 17'd65536) ? 17'd65536 : ratio_in;
      g  = shadow_cfg.ground_from_fixed ? shadow_cfg.ground_fixed_height : gh;
      vg = shadow_cfg.ground_from_fixed ? 1'b1 : (gv && r != 0);
      c  = shadow_cfg.ceil_from_fixed ? shadow_cfg.ceil_fixed_height : ch;
      vc = shadow_cfg.ceil_from_fixed ? 1'b1 : (cv && r != 0);
      ok = vg && vc;
      hc = 0;
      if (ok) begin
         p  = (c - g) * longint'(r) + 64'sd32768;
         hc = p >>> 16;   // floor, so ties go upward
         s  = 65'(net_sum) + 65'(hc);
         if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) net_sum = 64'h7FFF_FFFF_FFFF_FFFF;
         else if (s < -65'sh0_8000_0000_0000_0000) net_sum = 64'h8000_0000_0000_0000;
         else net_sum = s[63:0];
         if (hc > 0) added_sum = add_clamped(added_sum, hc, {1'b0, LIM63});
         else if (hc < 0) removed_sum = add_clamped(removed_sum, -hc, {1'b0, LIM63});
         surface_sum = add_clamped(surface_sum, r, {16'd0, LIM48});
         if (match_n != '1) match_n++;
      end else if (vg) begin
         if (ground_only_n != '1) ground_only_n++;
      end else if (vc) begin
         if (ceil_only_n != '1) ceil_only_n++;
      end

      // Shift the 3x3 window left by one column of upper, middle, current.
      window = {ok, middle_row[col_pos], upper_row[col_pos], window[8:3]};
      upper_row[col_pos]  = middle_row[col_pos];
      middle_row[col_pos] = ok;
      if (row_pos >= 2 && col_pos >= 2 && window[4]) begin
         nb = neighbour_sum + $countones(window & 9'h1EF);
         neighbour_sum = (nb > 29'h0FFF_FFFF) ? 28'hFFF_FFFF : nb[27:0];
         if (interior_n != '1) interior_n++;
      end

      last_col  = int'(col_pos) + 1 >= w;
      last_cell = last_col && int'(row_pos) + 1 >= h;
      res = '{height: hc[32:0], valid: ok, last: last_cell, net: '0, added: '0,
              removed: '0, surface: '0, matching: '0, ground_only: '0, ceil_only: '0,
              neighbours: '0, interior: '0};
      if (last_cell) begin
         if (net_sum < 0)
            res.net = -scale_by_area(-net_sum, shadow_cfg.cell_area, 64'h8000_0000_0000_0000);
         else
            res.net = scale_by_area(net_sum, shadow_cfg.cell_area, {1'b0, LIM63});
         res.added       = scale_by_area(added_sum, shadow_cfg.cell_area, {1'b0, LIM63});
         res.removed     = scale_by_area(removed_sum, shadow_cfg.cell_area, {1'b0, LIM63});
         res.surface     = scale_by_area(surface_sum, shadow_cfg.cell_area, {1'b0, LIM63});
         res.matching    = match_n;
         res.ground_only = ground_only_n;
         res.ceil_only   = ceil_only_n;
         res.neighbours  = neighbour_sum;
         res.interior    = interior_n;
         // Clear everything but the line stores for the next grid.
         row_pos = 0; col_pos = 0; net_sum = 0; added_sum = 0; removed_sum = 0;
         surface_sum = 0; match_n = 0; ground_only_n = 0; ceil_only_n = 0;
         neighbour_sum = 0; interior_n = 0; window = 0;
      end else if (last_col) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
      return res;
   endfunction

   // Register write: setup cycle, then access cycle, at whose end the write lands.
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_GROUND_FROM_FIXED:   shadow_cfg.ground_from_fixed   = val[0];
         REG_GROUND_FIXED_HEIGHT: shadow_cfg.ground_fixed_height = val;
         REG_CEIL_FROM_FIXED:     shadow_cfg.ceil_from_fixed     = val[0];
         REG_CEIL_FIXED_HEIGHT:   shadow_cfg.ceil_fixed_height   = val;
         REG_GRID_WIDTH:          shadow_cfg.grid_width          = val[12:0];
         REG_GRID_HEIGHT:         shadow_cfg.grid_height         = val[12:0];
         REG_CELL_AREA:           shadow_cfg.cell_area           = val;
         default: ;
      endcase
   endtask

   // Offer one cell, hold it until taken, then maybe idle for a burst.
   task automatic send_cell(logic signed [31:0] gh, logic gv, logic signed [31:0] ch,
                            logic cv, logic [16:0] ratio);
      req.valid         <= 1'b1;
      req.ground_height <= gh;
      req.ground_valid  <= gv;
      req.ceil_height   <= ch;
      req.ceil_valid    <= cv;
      req.area_ratio    <= ratio;
      do @(posedge clock); while (!req.ready);
      pending_reports.push_back(predict_cell(gh, gv, ch, cv, ratio));
      cells_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_random_cell();
      logic signed [31:0] gh, ch;
      logic [16:0]        ratio;
      case ($urandom_range(0, 3))
         0: begin gh = $urandom; ch = $urandom; end
         1: begin gh = $urandom_range(0, 8191) - 4096; ch = $urandom_range(0, 8191) - 4096; end
         2: begin gh = 32'sh8000_0000; ch = 32'sh7FFF_FFFF; end
         default: begin gh = $urandom_range(0, 255); ch = gh + $urandom_range(0, 511) - 256; end
      endcase
      case ($urandom_range(0, 9))
         0:       ratio = 17'd0;
         1, 2, 3: ratio = $urandom_range(0, 131071);
         4:       ratio = $urandom_range(1, 40);
         default: ratio = 17'd65536;
      endcase
      send_cell(gh, $urandom_range(0, 9) != 0, ch, $urandom_range(0, 9) != 0, ratio);
   endtask

   // Drop valid, wait for every expected report, then let the back end settle.
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_sources(logic gfix, logic [31:0] gval, logic cfix, logic [31:0] cval);
      write_reg(REG_GROUND_FROM_FIXED, gfix);
      write_reg(REG_GROUND_FIXED_HEIGHT, gval);
      write_reg(REG_CEIL_FROM_FIXED, cfix);
      write_reg(REG_CEIL_FIXED_HEIGHT, cval);
   endtask

   task automatic set_grid(logic [31:0] w, logic [31:0] h, logic [31:0] area);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      write_reg(REG_CELL_AREA, area);
   endtask

   // One-cell grids after reset: height extremes, validity, ratio of zero, whole and above.
   task automatic test_field_extremes();
      send_cell(32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 1'b1, 17'd65536);
      send_cell(32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, 1'b1, 17'd65536);
      send_cell(32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, 1'b1, 17'h1FFFF);
      send_cell(32'sd10, 1'b1, 32'sd20, 1'b1, 17'd0);
      send_cell(32'sd10, 1'b1, 32'sd20, 1'b0, 17'd65536);
      send_cell(32'sd10, 1'b0, 32'sd20, 1'b1, 17'd65536);
      send_cell(32'sd0, 1'b0, 32'sd0, 1'b0, 17'd65536);
      send_cell(32'sd0, 1'b1, 32'sd1, 1'b1, 17'd32768);    // tie, rounds up
      send_cell(32'sd1, 1'b1, 32'sd0, 1'b1, 17'd32768);    // negative tie
      send_cell(32'sd0, 1'b1, 32'sd3, 1'b1, 17'd1);
      drain();
   endtask

   // Fixed sources are always valid, even with a zero ratio; area at its extremes.
   task automatic test_fixed_sources();
      set_sources(1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
      set_grid(3, 2, 32'hFFFF_FFFF);
      repeat (6) send_random_cell();
      drain();
      set_sources(1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0);
      write_reg(REG_CELL_AREA, 32'h0);
      send_cell(32'sd0, 1'b0, 32'sh8000_0000, 1'b1, 17'd0);
      repeat (5) send_random_cell();
      drain();
      set_sources(1'b0, 32'h0, 1'b1, 32'h0000_0100);
      write_reg(REG_CELL_AREA, 32'd65536);
      repeat (6) send_random_cell();
      drain();
      set_sources(1'b0, 32'h0, 1'b0, 32'h0);
   endtask

   // Zero sizes clamp to one; a shrink in mid-grid ends the row and the grid early.
   task automatic test_size_edges();
      set_grid(0, 0, 32'd65536);
      send_random_cell();
      drain();
      set_grid(6, 4, 32'd65536);
      repeat (9) send_random_cell();
      drain();
      write_reg(REG_GRID_WIDTH, 2);
      write_reg(REG_GRID_HEIGHT, 2);
      send_random_cell();
      drain();
   endtask

   // Oversize register values clamp to the maxima; a shrink then ends each grid early.
   task automatic test_largest_grids();
      set_grid(13'h1FFF, 1, 32'd65536);
      repeat (150) send_random_cell();
      drain();
      write_reg(REG_GRID_WIDTH, 2);
      send_random_cell();
      drain();
      set_grid(3, 13'h1FFF, 32'd98304);
      repeat (150) send_random_cell();
      drain();
      write_reg(REG_GRID_HEIGHT, 2);
      repeat (3) send_random_cell();
      drain();
   endtask

   // Small whole grids under random settings; the last stretch runs without idling.
   task automatic test_random_grids();
      int w, h, grids;
      while (cells_sent < 790) begin
         if (cells_sent > 690) calm = 1'b1;
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         set_sources($urandom_range(0, 4) == 0, $urandom, $urandom_range(0, 4) == 0, $urandom);
         case ($urandom_range(0, 3))
            0: set_grid(w, h, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            1: set_grid(w, h, $urandom);
            default: set_grid(w, h, 32'd65536);
         endcase
         grids = $urandom_range(1, 3);
         repeat (grids * w * h) send_random_cell();
         drain();
      end
   endtask

   // Result side: stall in random bursts until the calm stretch.
   initial begin
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] got);
      if (got !== exp) begin
         $display("%0t %s expected %h actual %h", $time, name, exp, got);
         errors++;
      end
   endtask

   // Compare each accepted report with the oldest prediction.
   always @(posedge clock) begin
      cell_report_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t unexpected report: expected none, actual height %h",
                     $time, rsp.cell_height);
            errors++;
         end else begin
            e = pending_reports.pop_front();
            check_field("cell_height", e.height, rsp.cell_height);
            check_field("cell_valid", e.valid, rsp.cell_valid);
            check_field("report_ready", e.last, rsp.report_ready);
            check_field("net_volume", e.net, rsp.net_volume);
            check_field("added_volume", e.added, rsp.added_volume);
            check_field("removed_volume", e.removed, rsp.removed_volume);
            check_field("surface_area", e.surface, rsp.surface_area);
            check_field("matching_cells", e.matching, rsp.matching_cells);
            check_field("ground_only_cells", e.ground_only, rsp.ground_only_cells);
            check_field("ceil_only_cells", e.ceil_only, rsp.ceil_only_cells);
            check_field("neighbor_sum", e.neighbours, rsp.neighbor_sum);
            check_field("interior_valid_cells", e.interior, rsp.interior_valid_cells);
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req.valid         <= 1'b0;
      req.ground_height <= '0;
      req.ground_valid  <= 1'b0;
      req.ceil_height   <= '0;
      req.ceil_valid    <= 1'b0;
      req.area_ratio    <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_fixed_sources();
      test_size_edges();
      test_largest_grids();
      test_random_grids();
      drain();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
